FILE: rtl/lbp_pkg.sv
// package: types, codes and helpers shared by the buffer replacement unit
`default_nettype none

package lbp_pkg;

  localparam int unsigned SLOTS          = 40;
  localparam int unsigned BLOCK_TAG_BITS = 16;
  localparam int unsigned FILE_TAG_BITS  = 3;

  localparam int unsigned SLOT_W  = $clog2(SLOTS);
  localparam int unsigned RANK_W  = $clog2(SLOTS);
  localparam int unsigned COUNT_W = $clog2(SLOTS + 1);

  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_CLOSE = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  localparam logic [2:0] KIND_HIT       = 3'd0;
  localparam logic [2:0] KIND_MISS_FREE = 3'd1;
  localparam logic [2:0] KIND_EVICT     = 3'd2;
  localparam logic [2:0] KIND_FLUSHED   = 3'd3;
  localparam logic [2:0] KIND_DONE      = 3'd4;

  typedef struct packed {
    logic [1:0]                mode;
    logic [FILE_TAG_BITS-1:0]  file_id;
    logic [BLOCK_TAG_BITS-1:0] block_number;
  } in_item_t;

  typedef struct packed {
    logic [2:0]                kind;
    logic [SLOT_W-1:0]         slot;
    logic                      writeback;
    logic [FILE_TAG_BITS-1:0]  victim_file;
    logic [BLOCK_TAG_BITS-1:0] victim_block;
    logic                      last;
  } out_item_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_TOUCH,
    CELL_FILL,
    CELL_EVICT,
    CELL_FLUSH
  } cell_op_e;

  typedef struct packed {
    cell_op_e                  op;
    logic [RANK_W-1:0]         ref_rank;
    logic [RANK_W-1:0]         new_rank;
    logic [FILE_TAG_BITS-1:0]  file;
    logic [BLOCK_TAG_BITS-1:0] blk;
    logic                      wr;
  } cell_ctl_t;

  typedef struct packed {
    logic [FILE_TAG_BITS-1:0]  file;
    logic [BLOCK_TAG_BITS-1:0] blk;
  } lookup_t;

  typedef struct packed {
    logic                      valid;
    logic                      dirty;
    logic                      hit;
    logic                      fmatch;
    logic                      lru;
    logic [RANK_W-1:0]         rank;
    logic [FILE_TAG_BITS-1:0]  file;
    logic [BLOCK_TAG_BITS-1:0] blk;
  } cell_stat_t;

  function automatic logic [SLOT_W-1:0] first_one(input logic [SLOTS-1:0] vec);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (vec[i]) begin
        idx = SLOT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/lbp_cell.sv
// one buffer slot: tags, dirty bit and recency rank with local compare
`default_nettype none

module lbp_cell
  import lbp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctl_t  ctl_i,
  input  logic       sel_i,
  input  lookup_t    look_i,
  output cell_stat_t stat_o
);

  logic                      valid_q, valid_d;
  logic                      dirty_q, dirty_d;
  logic [RANK_W-1:0]         rank_q, rank_d;
  logic [FILE_TAG_BITS-1:0]  file_q, file_d;
  logic [BLOCK_TAG_BITS-1:0] blk_q, blk_d;
  logic                      dec;

  always_comb begin
    valid_d = valid_q;
    dirty_d = dirty_q;
    rank_d  = rank_q;
    file_d  = file_q;
    blk_d   = blk_q;
    dec     = valid_q && (rank_q > ctl_i.ref_rank);
    case (ctl_i.op)
      CELL_TOUCH: begin
        if (sel_i) begin
          rank_d = ctl_i.new_rank;
          if (ctl_i.wr) begin
            dirty_d = 1'b1;
          end
        end else if (dec) begin
          rank_d = rank_q - 1'b1;
        end
      end
      CELL_EVICT: begin
        if (sel_i) begin
          file_d  = ctl_i.file;
          blk_d   = ctl_i.blk;
          dirty_d = ctl_i.wr;
          rank_d  = ctl_i.new_rank;
        end else if (dec) begin
          rank_d = rank_q - 1'b1;
        end
      end
      CELL_FILL: begin
        if (sel_i) begin
          valid_d = 1'b1;
          file_d  = ctl_i.file;
          blk_d   = ctl_i.blk;
          dirty_d = ctl_i.wr;
          rank_d  = ctl_i.new_rank;
        end
      end
      CELL_FLUSH: begin
        if (sel_i) begin
          valid_d = 1'b0;
          dirty_d = 1'b0;
        end else if (dec) begin
          rank_d = rank_q - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      dirty_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      dirty_q <= dirty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rank_q <= rank_d;
    file_q <= file_d;
    blk_q  <= blk_d;
  end

  assign stat_o.valid  = valid_q;
  assign stat_o.dirty  = dirty_q;
  assign stat_o.hit    = valid_q && (file_q == look_i.file) && (blk_q == look_i.blk);
  assign stat_o.fmatch = valid_q && (file_q == look_i.file);
  assign stat_o.lru    = valid_q && (rank_q == '0);
  assign stat_o.rank   = rank_q;
  assign stat_o.file   = file_q;
  assign stat_o.blk    = blk_q;

endmodule

`default_nettype wire

FILE: rtl/lru_buffer_pool_replacement.sv
// top level: lru block-buffer tag and replacement unit over a row of slot cells
//
//   channel | signals                            | item
//   in      | in_valid_i / in_ready_o / in_item_i    | access or close request
//   out     | out_valid_o / out_ready_i / out_item_o | hit, miss, flush or done result
//
// a read or write access registers the tag compare in all cells at the accept edge, then
// picks the slot and updates ranks; a close flushes each slot of its file, one flush per
// cycle if the output can take it, then the done result; unused mode gives no result.
// a full output register stalls the unit until taken. no clearing pass after reset.
`default_nettype none

module lru_buffer_pool_replacement
  import lbp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_CLOSE
  } state_e;

  state_e                    state_q, state_d;
  logic                      wr_q, wr_d;
  logic [FILE_TAG_BITS-1:0]  file_q, file_d;
  logic [BLOCK_TAG_BITS-1:0] blk_q, blk_d;
  logic [SLOTS-1:0]          hit_q, hit_d;
  logic [SLOTS-1:0]          free_q, free_d;
  logic [SLOTS-1:0]          lru_q, lru_d;
  logic [SLOTS-1:0]          flush_q, flush_d;
  logic [COUNT_W-1:0]        count_q, count_d;
  logic                      out_valid_q, out_valid_d;
  out_item_t                 out_q, out_d;

  cell_ctl_t                 ctl;
  lookup_t                   look;
  cell_stat_t                stat [SLOTS];
  logic [SLOTS-1:0]          sel;
  logic [SLOTS-1:0]          hit_vec, free_vec, lru_vec, fm_vec;
  logic [SLOT_W-1:0]         pick;
  logic                      in_acc;
  logic                      can_emit;

  assign look.file = in_item_i.file_id;
  assign look.blk  = in_item_i.block_number;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    lbp_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .sel_i  (sel[g]),
      .look_i (look),
      .stat_o (stat[g])
    );
    assign hit_vec[g]  = stat[g].hit;
    assign free_vec[g] = !stat[g].valid;
    assign lru_vec[g]  = stat[g].lru;
    assign fm_vec[g]   = stat[g].fmatch;
    assign sel[g]      = (pick == SLOT_W'(g));
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign can_emit    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    state_d     = state_q;
    wr_d        = wr_q;
    file_d      = file_q;
    blk_d       = blk_q;
    hit_d       = hit_q;
    free_d      = free_q;
    lru_d       = lru_q;
    flush_d     = flush_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    pick        = '0;
    ctl.op       = CELL_HOLD;
    ctl.ref_rank = '0;
    ctl.new_rank = RANK_W'(count_q - 1'b1);
    ctl.file     = file_q;
    ctl.blk      = blk_q;
    ctl.wr       = wr_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          wr_d    = (in_item_i.mode == MODE_WRITE);
          file_d  = in_item_i.file_id;
          blk_d   = in_item_i.block_number;
          hit_d   = hit_vec;
          free_d  = free_vec;
          lru_d   = lru_vec;
          flush_d = fm_vec;
          case (in_item_i.mode)
            MODE_READ, MODE_WRITE: state_d = ST_ACCESS;
            MODE_CLOSE:            state_d = ST_CLOSE;
            default:               state_d = ST_IDLE;
          endcase
        end
      end
      ST_ACCESS: begin
        if (can_emit) begin
          out_valid_d = 1'b1;
          out_d       = '0;
          out_d.last  = 1'b1;
          state_d     = ST_IDLE;
          if (|hit_q) begin
            pick         = first_one(hit_q);
            ctl.op       = CELL_TOUCH;
            ctl.ref_rank = stat[pick].rank;
            out_d.kind   = KIND_HIT;
            out_d.slot   = pick;
          end else if (|free_q) begin
            pick         = first_one(free_q);
            ctl.op       = CELL_FILL;
            ctl.new_rank = RANK_W'(count_q);
            count_d      = count_q + 1'b1;
            out_d.kind   = KIND_MISS_FREE;
            out_d.slot   = pick;
          end else begin
            pick               = first_one(lru_q);
            ctl.op             = CELL_EVICT;
            ctl.ref_rank       = stat[pick].rank;
            out_d.kind         = KIND_EVICT;
            out_d.slot         = pick;
            out_d.writeback    = stat[pick].dirty;
            out_d.victim_file  = stat[pick].file;
            out_d.victim_block = stat[pick].blk;
          end
        end
      end
      ST_CLOSE: begin
        if (can_emit) begin
          out_valid_d = 1'b1;
          out_d       = '0;
          if (|flush_q) begin
            pick               = first_one(flush_q);
            ctl.op             = CELL_FLUSH;
            ctl.ref_rank       = stat[pick].rank;
            flush_d[pick]      = 1'b0;
            count_d            = count_q - 1'b1;
            out_d.kind         = KIND_FLUSHED;
            out_d.slot         = pick;
            out_d.writeback    = stat[pick].dirty;
            out_d.victim_file  = stat[pick].file;
            out_d.victim_block = stat[pick].blk;
          end else begin
            out_d.kind = KIND_DONE;
            out_d.last = 1'b1;
            state_d    = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wr_q        <= 1'b0;
      file_q      <= '0;
      blk_q       <= '0;
      hit_q       <= '0;
      free_q      <= '0;
      lru_q       <= '0;
      flush_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      wr_q        <= wr_d;
      file_q      <= file_d;
      blk_q       <= blk_d;
      hit_q       <= hit_d;
      free_q      <= free_d;
      lru_q       <= lru_d;
      flush_q     <= flush_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lbp_checker.sv
// port checker for the buffer replacement unit and its bind
`default_nettype none

module lbp_checker
  import lbp_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_item_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result item changed while stalled");

  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.last == (out_item_o.kind != KIND_FLUSHED)))
    else $error("last flag does not match result kind");

  a_clean_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.kind == KIND_HIT || out_item_o.kind == KIND_MISS_FREE ||
                    out_item_o.kind == KIND_DONE)
    |-> !out_item_o.writeback && out_item_o.victim_file == '0 &&
        out_item_o.victim_block == '0)
    else $error("victim fields set on a result without victim");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.slot < SLOT_W'(SLOTS - 1) || out_item_o.slot == SLOT_W'(SLOTS - 1))
    else $error("slot number out of range");

  a_busy_after_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_item_i.mode != MODE_NONE |=> !in_ready_o)
    else $error("new item taken while access in progress");

endmodule

bind lru_buffer_pool_replacement lbp_checker u_lbp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire

FILE: sim/lbp_result_checker.sv
// checker: watches both channels, predicts each result of the replacement unit and compares
`timescale 1ns / 1ps

module lbp_result_checker
  import lbp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_item_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_item_i,
  output int        mismatches_o,
  output int        pending_o
);

  logic                      slot_used  [SLOTS];
  logic [FILE_TAG_BITS-1:0]  slot_file  [SLOTS];
  logic [BLOCK_TAG_BITS-1:0] slot_blk   [SLOTS];
  logic                      slot_dirty [SLOTS];
  logic [RANK_W-1:0]         slot_rank  [SLOTS];
  int unsigned               resident;

  out_item_t predicted_outcomes[$];
  int        mismatches;

  task automatic make_most_recent(input int s);
    logic [RANK_W-1:0] r;
    r = slot_rank[s];
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_used[i] && i != s && slot_rank[i] > r) begin
        slot_rank[i]--;
      end
    end
    slot_rank[s] = RANK_W'(resident - 1);
  endtask

  task automatic lookup_and_replace(input in_item_t it);
    out_item_t         res;
    logic [RANK_W-1:0] gone_rank;
    int                found;
    found = -1;
    res   = '0;
    if (it.mode == MODE_NONE) begin
      return;
    end
    if (it.mode == MODE_CLOSE) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_used[i] && slot_file[i] == it.file_id) begin
          res              = '0;
          res.kind         = KIND_FLUSHED;
          res.slot         = SLOT_W'(i);
          res.writeback    = slot_dirty[i];
          res.victim_file  = slot_file[i];
          res.victim_block = slot_blk[i];
          predicted_outcomes.push_back(res);
          gone_rank     = slot_rank[i];
          slot_used[i]  = 1'b0;
          slot_dirty[i] = 1'b0;
          for (int j = 0; j < SLOTS; j++) begin
            if (slot_used[j] && slot_rank[j] > gone_rank) begin
              slot_rank[j]--;
            end
          end
          resident--;
        end
      end
      res      = '0;
      res.kind = KIND_DONE;
      res.last = 1'b1;
      predicted_outcomes.push_back(res);
      return;
    end
    res.last = 1'b1;
    for (int i = 0; i < SLOTS; i++) begin
      if (found < 0 && slot_used[i] && slot_file[i] == it.file_id &&
          slot_blk[i] == it.block_number) begin
        found = i;
      end
    end
    if (found >= 0) begin
      make_most_recent(found);
      if (it.mode == MODE_WRITE) begin
        slot_dirty[found] = 1'b1;
      end
      res.kind = KIND_HIT;
      res.slot = SLOT_W'(found);
      predicted_outcomes.push_back(res);
      return;
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (found < 0 && !slot_used[i]) begin
        found = i;
      end
    end
    if (found >= 0) begin
      slot_used[found]  = 1'b1;
      slot_file[found]  = it.file_id;
      slot_blk[found]   = it.block_number;
      slot_dirty[found] = (it.mode == MODE_WRITE);
      slot_rank[found]  = RANK_W'(resident);
      resident++;
      res.kind = KIND_MISS_FREE;
      res.slot = SLOT_W'(found);
      predicted_outcomes.push_back(res);
      return;
    end
    found = 0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (slot_used[i] && slot_rank[i] == '0) begin
        found = i;
      end
    end
    res.kind         = KIND_EVICT;
    res.slot         = SLOT_W'(found);
    res.writeback    = slot_dirty[found];
    res.victim_file  = slot_file[found];
    res.victim_block = slot_blk[found];
    predicted_outcomes.push_back(res);
    slot_file[found]  = it.file_id;
    slot_blk[found]   = it.block_number;
    slot_dirty[found] = (it.mode == MODE_WRITE);
    make_most_recent(found);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_used[i]  = 1'b0;
        slot_file[i]  = '0;
        slot_blk[i]   = '0;
        slot_dirty[i] = 1'b0;
        slot_rank[i]  = '0;
      end
      resident = 0;
      predicted_outcomes.delete();
      mismatches = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (predicted_outcomes.size() == 0) begin
          $error("result with nothing expected: kind %0d slot %0d",
                 out_item_i.kind, out_item_i.slot);
          mismatches++;
        end else begin
          want = predicted_outcomes.pop_front();
          check_field("kind", 32'(want.kind), 32'(out_item_i.kind));
          check_field("slot", 32'(want.slot), 32'(out_item_i.slot));
          check_field("writeback", 32'(want.writeback), 32'(out_item_i.writeback));
          check_field("victim_file", 32'(want.victim_file), 32'(out_item_i.victim_file));
          check_field("victim_block", 32'(want.victim_block),
                      32'(out_item_i.victim_block));
          check_field("last", 32'(want.last), 32'(out_item_i.last));
        end
      end
      if (in_valid_i && in_ready_i) begin
        lookup_and_replace(in_item_i);
      end
    end
    mismatches_o <= mismatches;
    pending_o    <= predicted_outcomes.size();
  end

endmodule

FILE: sim/tb_lru_buffer_pool_replacement.sv
// testbench top: clock, reset, request stimulus, result back-pressure and final verdict
`timescale 1ns / 1ps

module tb_lru_buffer_pool_replacement;
  import lbp_pkg::*;

  localparam int ACCESS_COUNT = 400;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE       = 60;
  localparam int CYCLE_LIMIT  = 600000;

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  in_item_t  in_item_i   = '0;
  logic      out_ready_i = 1'b0;
  logic      in_ready_o;
  logic      out_valid_o;
  out_item_t out_item_o;

  int        mismatches;
  int        pending;
  int        send_idle_pct = 15;
  int        recv_idle_pct = 59;
  logic      hold_off_req  = 1'b0;
  int        cycles        = 0;
  lookup_t   recent_blocks[$];

  lru_buffer_pool_replacement dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  lbp_result_checker u_result_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_item_i    (in_item_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_i   (out_item_o),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("lru_buffer_pool_replacement verification failed");
    $finish;
  end

  // result side: random stalls plus one long hold-off on request
  initial begin
    int   hold_left;
    logic hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic in_item_t mk(input logic [1:0] mode, input int unsigned file,
                                  input int unsigned blk);
    in_item_t it;
    it.mode         = mode;
    it.file_id      = FILE_TAG_BITS'(file);
    it.block_number = BLOCK_TAG_BITS'(blk);
    return it;
  endfunction

  function automatic in_item_t next_request();
    in_item_t    it;
    lookup_t     pick;
    int unsigned roll;
    roll = $urandom_range(99);
    it   = mk(($urandom_range(1) != 0) ? MODE_WRITE : MODE_READ, $urandom_range(7), $urandom);
    if (recent_blocks.size() > 0) begin
      pick = recent_blocks[$urandom_range(recent_blocks.size() - 1)];
    end else begin
      pick = '0;
    end
    if (roll < 4) begin
      it.mode = MODE_CLOSE;
      if ($urandom_range(1) != 0) begin
        it.file_id = pick.file;
      end
    end else if (roll < 8) begin
      it.mode = MODE_NONE;
    end else if (roll < 55 && recent_blocks.size() > 0) begin
      it.file_id      = pick.file;
      it.block_number = pick.blk;
    end
    return it;
  endfunction

  task automatic send(input in_item_t it);
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    in_item_t it;
    int       accesses;
    int       phase;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // close with nothing resident, fills, hits, ignored mode, dirty and clean flushes
    send(mk(MODE_CLOSE, 5, 16'h1234));
    send(mk(MODE_READ, 0, 0));
    send(mk(MODE_WRITE, 7, 16'hffff));
    send(mk(MODE_READ, 0, 0));
    send(mk(MODE_WRITE, 0, 0));
    send(mk(MODE_NONE, 7, 16'hffff));
    send(mk(MODE_READ, 7, 16'hffff));
    send(mk(MODE_WRITE, 3, 16'haaaa));
    send(mk(MODE_READ, 3, 16'h5555));
    send(mk(MODE_CLOSE, 7, 0));
    send(mk(MODE_CLOSE, 0, 16'hffff));
    send(mk(MODE_READ, 0, 0));
    send(mk(MODE_CLOSE, 3, 0));
    send(mk(MODE_NONE, 0, 0));
    send(mk(MODE_WRITE, 4, 16'h8001));
    send(mk(MODE_READ, 4, 16'h8001));
    drain();

    accesses = 0;
    phase    = 0;
    while (accesses < ACCESS_COUNT) begin
      if (accesses / (ACCESS_COUNT / 3) > phase && phase < 2) begin
        phase++;
        drain();
        if (phase == 1) begin
          send_idle_pct = 59;
          recv_idle_pct = 15;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          hold_off_req  = 1'b1;
        end
      end
      it = next_request();
      send(it);
      if (it.mode != MODE_NONE) begin
        accesses++;
      end
      if (it.mode == MODE_READ || it.mode == MODE_WRITE) begin
        recent_blocks.push_back('{file: it.file_id, blk: it.block_number});
        if (recent_blocks.size() > 64) begin
          void'(recent_blocks.pop_front());
        end
      end
    end

    drain();
    repeat (SETTLE) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("lru_buffer_pool_replacement verification clean");
    end else begin
      $display("lru_buffer_pool_replacement verification failed");
    end
    $finish;
  end

endmodule

FILE: lru_buffer_pool_replacement.f
rtl/lbp_pkg.sv
rtl/lbp_cell.sv
rtl/lru_buffer_pool_replacement.sv
rtl/lbp_checker.sv
sim/lbp_result_checker.sv
sim/tb_lru_buffer_pool_replacement.sv
